// ===== hdl/bfa_pkg.sv =====
// Shared constants and types of the box filter antialias block.
package bfa_pkg;

  localparam int CH_W          = 13;
  localparam int PIX_W         = 3 * CH_W;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 64;
  localparam int POS_W         = 10;
  localparam int POS_LIMIT     = 1024;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int RAD_W         = 3;
  localparam int FRACTION_BITS = 12;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(2);

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1);
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1000);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1000);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ===== hdl/box_filter_antialias.sv =====
// Box filter antialias: windowed mean over a line store with a shared serial divider.
// After an interior pixel is accepted, its window is read entry by entry from the line store,
// the last read is drained, the shared divider runs over the three channels in turn
// and the output word is loaded.
// The input reopens once that word is loaded, so it stays closed while an older word still
// waits for the receiver; a border pixel does not make the block busy.
// Reset is synchronous, active high: positions clear, radius 1, 1000x1000 frame.
module box_filter_antialias
  import bfa_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input pixels.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in, zero pad
  input  logic [0:0]            s_tuser,   // frame_start
  // Filtered pixels.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_col, out_row, red_out, green_out,
                                           // blue_out, zero pad
  output logic                  m_tlast,   // frame_done
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  // The radius register holds at most 7, so the window never exceeds 15x15.
  localparam int RAD_CAP   = (MAX_RADIUS < 7) ? MAX_RADIUS : 7;
  localparam int ROW_SLOTS = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W    = $clog2(ROW_SLOTS);
  localparam int ADDR_W    = $clog2(ROW_SLOTS * MAX_WIDTH);
  localparam int AREA_MAX  = (2 * RAD_CAP + 1) * (2 * RAD_CAP + 1);
  localparam int AREA_W    = $clog2(AREA_MAX + 1);
  localparam int SUM_W     = CH_W + $clog2(AREA_MAX);
  localparam int NUM_W     = SUM_W + 1;
  localparam int STEP_W    = $clog2(NUM_W);
  localparam int WIDTH_LIM = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
  localparam int SIDE_W    = RAD_W + 1;

  localparam logic [NUM_W-1:0] ONE_Q   = NUM_W'(1 << FRACTION_BITS);
  localparam logic [1:0]       CH_RED   = 2'd0;
  localparam logic [1:0]       CH_GREEN = 2'd1;
  localparam logic [1:0]       CH_BLUE  = 2'd2;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(ROW_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(ROW_SLOTS - 1) : s - SLOT_W'(1);
  endfunction

  // Configuration registers.
  logic [RAD_W-1:0] radius;
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RADIUS_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: radius       <= cfg_data[RAD_W-1:0];
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry. Config must only be written while the block is idle (the block does
  // not enforce this itself), so that these are stable across the processing of one pixel.
  logic [RAD_W-1:0]  r_eff;
  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] side1;
  logic [7:0]        area_full;
  logic [AREA_W-1:0] area;
  logic [CFG_W-1:0]  w_eff;
  logic [CFG_W-1:0]  h_eff;

  always_comb begin
    r_eff     = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
    side      = {r_eff, 1'b0};
    side1     = side + SIDE_W'(1);
    area_full = {4'b0, side1} * {4'b0, side1};
    area      = AREA_W'(area_full);
    if (image_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (int'(image_width) > WIDTH_LIM) begin
      w_eff = CFG_W'(WIDTH_LIM);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (int'(image_height) > POS_LIMIT) begin
      h_eff = CFG_W'(POS_LIMIT);
    end else begin
      h_eff = image_height;
    end
  end

  state_t state, state_next;

  // Raster position of the next pixel, with the row's line-store slot (row mod slots).
  logic [POS_W-1:0]  col_pos;
  logic [POS_W-1:0]  row_pos;
  logic [SLOT_W-1:0] row_slot;

  logic              accept;
  logic              frame_start;
  logic [POS_W-1:0]  pre_col;
  logic [POS_W:0]    pre_row;
  logic [SLOT_W-1:0] pre_slot;
  logic              wrap_c;
  logic              wrap_r;
  logic [POS_W:0]    mid_row;
  logic [SLOT_W-1:0] mid_slot;
  logic [POS_W-1:0]  cur_col_c;
  logic [POS_W-1:0]  cur_row_c;
  logic [SLOT_W-1:0] cur_slot_c;
  logic [POS_W:0]    nxt_col;
  logic [POS_W:0]    nxt_row;
  logic              end_row;
  logic              end_frame;
  logic              emit;
  logic [ADDR_W-1:0] wr_addr;

  assign accept      = s_tvalid && s_tready;
  assign frame_start = s_tuser[0];

  // Position of the arriving pixel: restart on frame start, then wrap a column or row
  // that the current geometry no longer covers.
  always_comb begin
    pre_col    = frame_start ? '0 : col_pos;
    pre_row    = frame_start ? '0 : {1'b0, row_pos};
    pre_slot   = frame_start ? '0 : row_slot;
    wrap_c     = {1'b0, pre_col} >= w_eff;
    mid_row    = wrap_c ? pre_row + (POS_W + 1)'(1) : pre_row;
    mid_slot   = wrap_c ? slot_inc(pre_slot) : pre_slot;
    wrap_r     = mid_row >= h_eff;
    cur_col_c  = wrap_c ? '0 : pre_col;
    cur_row_c  = wrap_r ? '0 : mid_row[POS_W-1:0];
    cur_slot_c = wrap_r ? '0 : mid_slot;
    nxt_col    = {1'b0, cur_col_c} + (POS_W + 1)'(1);
    nxt_row    = {1'b0, cur_row_c} + (POS_W + 1)'(1);
    end_row    = nxt_col >= w_eff;
    end_frame  = nxt_row >= h_eff;
    emit       = (r_eff != '0) && (cur_col_c >= POS_W'(side)) && (cur_row_c >= POS_W'(side));
    wr_addr    = ADDR_W'(cur_slot_c) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cur_col_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      row_slot <= '0;
    end else if (accept) begin
      if (end_row) begin
        col_pos <= '0;
        if (end_frame) begin
          row_pos  <= '0;
          row_slot <= '0;
        end else begin
          row_pos  <= nxt_row[POS_W-1:0];
          row_slot <= slot_inc(cur_slot_c);
        end
      end else begin
        col_pos  <= nxt_col[POS_W-1:0];
        row_pos  <= cur_row_c;
        row_slot <= cur_slot_c;
      end
    end
  end

  // Window walk: the newest row first, right to left, one entry per cycle.
  logic [POS_W-1:0]  cur_col;
  logic [POS_W-1:0]  cur_row;
  logic              cur_done;
  logic [SLOT_W-1:0] rd_slot;
  logic [POS_W-1:0]  rd_col;
  logic [SIDE_W-1:0] rd_j;
  logic [SIDE_W-1:0] rd_k;
  logic              rd_last;
  logic              rd_en;
  logic              rd_pending;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;

  assign rd_last = (rd_j == side) && (rd_k == side);
  assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col  <= cur_col_c;
      cur_row  <= cur_row_c;
      cur_done <= ({1'b0, cur_col_c} == w_eff - CFG_W'(1)) &&
                  ({1'b0, cur_row_c} == h_eff - CFG_W'(1));
      rd_slot  <= cur_slot_c;
      rd_col   <= cur_col_c;
      rd_j     <= '0;
      rd_k     <= '0;
    end else if (rd_en) begin
      if (rd_j == side) begin
        rd_j    <= '0;
        rd_col  <= cur_col;
        rd_k    <= rd_k + SIDE_W'(1);
        rd_slot <= slot_dec(rd_slot);
      end else begin
        rd_j   <= rd_j + SIDE_W'(1);
        rd_col <= rd_col - POS_W'(1);
      end
    end
  end

  // Line store: one write port for the arriving pixel, one registered read port.
  logic [PIX_W-1:0] line_mem [ROW_SLOTS * MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[wr_addr] <= s_tdata[PIX_W-1:0];
    end
    if (rd_en) begin
      rd_data <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= rd_en;
    end
  end

  // Channel sums, gathered one entry behind the read address.
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (rd_pending) begin
      sum_r <= sum_r + SUM_W'(rd_data[CH_W-1:0]);
      sum_g <= sum_g + SUM_W'(rd_data[2*CH_W-1:CH_W]);
      sum_b <= sum_b + SUM_W'(rd_data[3*CH_W-1:2*CH_W]);
    end
  end

  // Shared restoring divider: (sum + area/2) / area, one quotient bit per cycle,
  // the three channels in turn.
  logic [1:0]        div_ch;
  logic [STEP_W-1:0] div_step;
  logic [NUM_W-1:0]  div_dq;
  logic [AREA_W-1:0] div_rem;
  logic [AREA_W:0]   trial;
  logic              fits;
  logic [AREA_W-1:0] rem_next;
  logic [NUM_W-1:0]  dq_next;
  logic [NUM_W-1:0]  q_clamped;
  logic [SUM_W-1:0]  sel_sum;
  logic              div_last;
  logic [CH_W-1:0]   res_r;
  logic [CH_W-1:0]   res_g;
  logic [CH_W-1:0]   res_b;

  always_comb begin
    trial     = {div_rem, div_dq[NUM_W-1]};
    fits      = trial >= {1'b0, area};
    rem_next  = fits ? AREA_W'(trial - {1'b0, area}) : trial[AREA_W-1:0];
    dq_next   = {div_dq[NUM_W-2:0], fits};
    q_clamped = (dq_next > ONE_Q) ? ONE_Q : dq_next;
    div_last  = (div_step == STEP_W'(NUM_W - 1));
    case (div_ch)
      CH_RED:   sel_sum = sum_r;
      CH_GREEN: sel_sum = sum_g;
      default:  sel_sum = sum_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      div_ch <= CH_RED;
    end else if (state == S_LOAD) begin
      div_dq   <= NUM_W'(sel_sum) + NUM_W'(area >> 1);
      div_rem  <= '0;
      div_step <= '0;
    end else if (state == S_DIV) begin
      div_dq   <= dq_next;
      div_rem  <= rem_next;
      div_step <= div_step + STEP_W'(1);
      if (div_last) begin
        case (div_ch)
          CH_RED:   res_r <= q_clamped[CH_W-1:0];
          CH_GREEN: res_g <= q_clamped[CH_W-1:0];
          default:  res_b <= q_clamped[CH_W-1:0];
        endcase
        div_ch <= div_ch + 2'd1;
      end
    end
  end

  // Sequencer.
  logic out_load;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && emit) state_next = S_READ;
      S_READ:  if (rd_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_LOAD;
      S_LOAD:  state_next = S_DIV;
      S_DIV: begin
        if (div_last) state_next = (div_ch == CH_BLUE) ? S_OUT : S_LOAD;
      end
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_READ:  rd_en    = 1'b1;
      S_OUT:   out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: lets the next pixel in while a finished word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_DATA_W - 2 * POS_W - PIX_W){1'b0}}, res_b, res_g, res_r,
                  cur_row - POS_W'(r_eff), cur_col - POS_W'(r_eff)};
      m_tlast <= cur_done;
    end
  end

  // A pixel whose window is incomplete leaves the block ready for the next one.
  a_border_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && !emit) |=> s_tready)
    else $error("border pixel made the block busy");

  // The window walk never leaves the square.
  a_walk_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_j <= side) && (rd_k <= side))
    else $error("window walk out of range");

  // The divider remainder stays below the window area.
  a_rem_below_area: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < area))
    else $error("divider remainder out of range");

  // Every delivered red channel is clamped to 1.0.
  a_red_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2*POS_W +: CH_W] <= ONE_Q[CH_W-1:0]))
    else $error("red channel above 1.0");

endmodule
